/* sv/tlps_pkg.sv */
// Shared types and constants for the pedestrian crossing sequencer.
// Holds the phase encoding, payload structs and config register indexes.
// No dependencies.
package tlps_pkg;

	typedef enum logic [2:0] {
		PH_GO    = 3'd0,
		PH_YEL1  = 3'd1,
		PH_WALK  = 3'd2,
		PH_BLINK = 3'd3,
		PH_YEL2  = 3'd4
	} phase_t;

	typedef struct packed {
		logic        button_level;
		logic [11:0] light_sample;
	} in_item_t;

	typedef struct packed {
		logic       ped_red;
		logic       ped_green;
		logic       car_red;
		logic       car_yellow;
		logic [9:0] pwm_duty;
	} out_item_t;

	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] REG_SLOT_MS    = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_SLOT_COUNT = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_CONFIRM_MS = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_YELLOW_MS  = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_WALK_MS    = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_BLINK_MS   = 3'd5;

	localparam logic [9:0]  SLOT_MS_RST    = 10'd100;
	localparam logic [6:0]  SLOT_COUNT_RST = 7'd80;
	localparam logic [7:0]  CONFIRM_MS_RST = 8'd10;
	localparam logic [15:0] YELLOW_MS_RST  = 16'd1000;
	localparam logic [15:0] WALK_MS_RST    = 16'd4000;
	localparam logic [15:0] BLINK_MS_RST   = 16'd500;

	localparam logic [11:0] SAMPLE_MIN = 12'd100;
	localparam logic [9:0]  DUTY_SCALE = 10'd1000;
	localparam logic [12:0] SAMPLE_MAX = 13'd4095;

	// max(sample,100)*1000/4095; quotient by 4096 is at most one short
	function automatic logic [9:0] duty_of(input logic [11:0] sample);
		logic [11:0] s;
		logic [21:0] prod;
		logic [9:0]  q;
		logic [12:0] r;
		s    = (sample < SAMPLE_MIN) ? SAMPLE_MIN : sample;
		prod = s * DUTY_SCALE;
		q    = prod[21:12];
		r    = {1'b0, prod[11:0]} + {3'b000, q};
		return (r >= SAMPLE_MAX) ? q + 10'd1 : q;
	endfunction

endpackage

/* sv/traffic_light_pedestrian_sequencer_unit.sv */
// Pedestrian crossing sequencer top level: input register, phase logic, result register.
// Depends on tlps_pkg.
//
// One input transfer per clock is accepted and yields exactly one result transfer via the input
// register and the result register; without output stalls the sustained rate is one item per
// clock, set by the single pass from the input register through the phase logic into the
// result register. Each item is one millisecond tick: the block walks car go (with PWM duty
// refreshed per slot from the light sample and early exit on a confirmed button press), car
// yellow, pedestrian walk, BLINK_TOGGLES pedestrian green toggles and car yellow again.
// Write configuration only while no item is in flight.
module traffic_light_pedestrian_sequencer_unit #(
	parameter int BLINK_TOGGLES = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  tlps_pkg::in_item_t               in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output tlps_pkg::out_item_t              out_data,
	input  logic                             cfg_we,
	input  logic [tlps_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [tlps_pkg::CfgDataW-1:0]    cfg_data
);
	import tlps_pkg::*;

	localparam int TW = (BLINK_TOGGLES > 2) ? $clog2(BLINK_TOGGLES) : 1;
	localparam logic [TW:0] TOGGLE_LAST = (TW+1)'(BLINK_TOGGLES);

	logic [9:0]  slot_ms_q;
	logic [6:0]  slot_count_q;
	logic [7:0]  confirm_ms_q;
	logic [15:0] yellow_ms_q;
	logic [15:0] walk_ms_q;
	logic [15:0] blink_ms_q;

	logic     valid_s1;
	in_item_t item_s1;

	phase_t      phase_q, phase_n, eff_phase;
	logic [15:0] tick_q, tick_n, eff_tick;
	logic [6:0]  slot_q, slot_n;
	logic [TW-1:0] toggle_q, toggle_n;
	logic        pending_q, pending_n;
	logic        prev_q, prev_n;
	logic [9:0]  duty_q, duty_n, duty_go;

	logic        advance;
	logic        out_valid_q;
	out_item_t   out_q, res;

	logic [9:0]  slot_m1;
	logic [15:0] yellow_e, walk_e, blink_e;
	logic [16:0] tick_inc;
	logic [TW:0] toggle_inc;
	logic        go_state, to_yel, leave, level;

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_ms_q    <= SLOT_MS_RST;
			slot_count_q <= SLOT_COUNT_RST;
			confirm_ms_q <= CONFIRM_MS_RST;
			yellow_ms_q  <= YELLOW_MS_RST;
			walk_ms_q    <= WALK_MS_RST;
			blink_ms_q   <= BLINK_MS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SLOT_MS:    slot_ms_q    <= cfg_data[9:0];
				REG_SLOT_COUNT: slot_count_q <= cfg_data[6:0];
				REG_CONFIRM_MS: confirm_ms_q <= cfg_data[7:0];
				REG_YELLOW_MS:  yellow_ms_q  <= cfg_data;
				REG_WALK_MS:    walk_ms_q    <= cfg_data;
				REG_BLINK_MS:   blink_ms_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	assign slot_m1  = (slot_ms_q == 10'd0) ? 10'd0 : slot_ms_q - 10'd1;
	assign yellow_e = (yellow_ms_q == 16'd0) ? 16'd1 : yellow_ms_q;
	assign walk_e   = (walk_ms_q == 16'd0) ? 16'd1 : walk_ms_q;
	assign blink_e  = (blink_ms_q == 16'd0) ? 16'd1 : blink_ms_q;
	assign level    = item_s1.button_level;
	assign go_state = !(phase_q == PH_YEL1 || phase_q == PH_WALK
		|| phase_q == PH_BLINK || phase_q == PH_YEL2);
	assign to_yel   = go_state && tick_q == 16'd0 && !pending_q && slot_q >= slot_count_q;
	assign eff_phase = to_yel ? PH_YEL1 : (go_state ? PH_GO : phase_q);
	assign eff_tick  = to_yel ? 16'd0 : tick_q;
	assign tick_inc  = {1'b0, eff_tick} + 17'd1;
	assign toggle_inc = {1'b0, toggle_q} + {{TW{1'b0}}, 1'b1};

	// next state
	always_comb begin
		phase_n   = eff_phase;
		tick_n    = eff_tick;
		slot_n    = slot_q;
		toggle_n  = toggle_q;
		pending_n = pending_q;
		prev_n    = prev_q;
		duty_n    = to_yel ? 10'd0 : duty_q;
		duty_go   = duty_q;
		leave     = 1'b0;
		unique case (eff_phase)
			PH_GO: begin
				if (tick_q != 16'd0) begin
					tick_n = tick_q - 16'd1;
				end else if (pending_q) begin
					pending_n = 1'b0;
					if (!level) begin
						prev_n = 1'b0;
						leave  = 1'b1;
					end else begin
						tick_n = {6'd0, slot_m1};
					end
				end else begin
					duty_go = duty_of(item_s1.light_sample);
					duty_n  = duty_go;
					slot_n  = slot_q + 7'd1;
					if (prev_q && !level) begin
						if (confirm_ms_q == 8'd0) begin
							prev_n = 1'b0;
							leave  = 1'b1;
						end else begin
							pending_n = 1'b1;
							tick_n    = {8'd0, confirm_ms_q - 8'd1};
						end
					end else begin
						if (level) begin
							prev_n = 1'b1;
						end
						tick_n = {6'd0, slot_m1};
					end
				end
				if (leave) begin
					phase_n = PH_YEL1;
					tick_n  = 16'd0;
					duty_n  = 10'd0;
				end
			end
			PH_YEL1: begin
				tick_n = tick_inc[15:0];
				if (tick_inc >= {1'b0, yellow_e}) begin
					phase_n = PH_WALK;
					tick_n  = 16'd0;
				end
			end
			PH_WALK: begin
				tick_n = tick_inc[15:0];
				if (tick_inc >= {1'b0, walk_e}) begin
					phase_n  = PH_BLINK;
					tick_n   = 16'd0;
					toggle_n = '0;
				end
			end
			PH_BLINK: begin
				tick_n = tick_inc[15:0];
				if (tick_inc >= {1'b0, blink_e}) begin
					tick_n   = 16'd0;
					toggle_n = toggle_inc[TW-1:0];
					if (toggle_inc >= TOGGLE_LAST) begin
						toggle_n = '0;
						phase_n  = PH_YEL2;
					end
				end
			end
			PH_YEL2: begin
				tick_n = tick_inc[15:0];
				if (tick_inc >= {1'b0, yellow_e}) begin
					phase_n   = PH_GO;
					tick_n    = 16'd0;
					slot_n    = 7'd0;
					pending_n = 1'b0;
					duty_n    = 10'd0;
				end
			end
			default: ;
		endcase
	end

	// result
	always_comb begin
		res = '0;
		unique case (eff_phase)
			PH_GO: begin
				res.ped_red  = 1'b1;
				res.pwm_duty = duty_go;
			end
			PH_YEL1, PH_YEL2: begin
				res.ped_red    = 1'b1;
				res.car_yellow = 1'b1;
			end
			PH_WALK: begin
				res.ped_green = 1'b1;
				res.car_red   = 1'b1;
			end
			PH_BLINK: begin
				res.ped_green = toggle_q[0];
				res.car_red   = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_GO;
			tick_q      <= 16'd0;
			slot_q      <= 7'd0;
			toggle_q    <= '0;
			pending_q   <= 1'b0;
			prev_q      <= 1'b1;
			duty_q      <= 10'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q   <= phase_n;
				tick_q    <= tick_n;
				slot_q    <= slot_n;
				toggle_q  <= toggle_n;
				pending_q <= pending_n;
				prev_q    <= prev_n;
				duty_q    <= duty_n;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");
	a_duty_only_car_go: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.pwm_duty != 10'd0) |-> (out_data.ped_red && !out_data.car_yellow))
		else $error("pwm duty outside car go");
	a_ped_lamps_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.ped_red && out_data.ped_green))
		else $error("both pedestrian lamps on");
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.pwm_duty <= DUTY_SCALE)
		else $error("pwm duty above full scale");

endmodule
